>>> design/rcoe_pkg.sv
// Package for the region cache directory with oldest-first eviction.
// Holds field widths, result status codes and the controller state type.
// No dependencies.
`default_nettype none

package rcoe_pkg;

    localparam int REGION_W   = 14;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 7;
    localparam int SLOT_OUT_W = 6;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 7'd40;

    localparam logic [STATUS_W-1:0] STAT_HIT           = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_LOADED        = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_KNOWN_MISSING = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NEW_MISSING   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FLUSHED       = 3'd4;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_FLUSH   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

>>> design/rcoe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the slot tags and load times and for the not-found marks.
// No dependencies.
`default_nettype none

module rcoe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/region_cache_oldest_evict.sv
// Region cache directory: fully associative slots, oldest-first eviction.
// A request is answered after one sequential pass over the slot RAM (one entry per cycle);
// flush and out-of-range requests skip the pass and go straight to the result.
// The input is ready again as the result appears, so a new request is taken only after the
// previous result is issued, which waits while m_tready holds back the result before it.
// After reset a clearing pass over all NUM_REGIONS not-found marks empties them; no input is
// taken meanwhile. Depends on rcoe_pkg and rcoe_ram.
`default_nettype none

module region_cache_oldest_evict import rcoe_pkg::*; #(
    parameter int CACHE_SLOTS = 64,
    parameter int NUM_REGIONS = 16384
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // region [13:0], now_seconds [45:14], load_ok [46], zero [47]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // action [0]
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // slot [5:0], evicted [6], evicted_region [20:7], zero [23:21]
    output logic      [M_TDATA_W-1:0] m_tdata,
    // status [2:0]
    output logic      [STATUS_W-1:0]  m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int SLOT_W  = $clog2(CACHE_SLOTS);
    localparam int OCC_W   = $clog2(CACHE_SLOTS + 1);
    localparam int REG_AW  = $clog2(NUM_REGIONS);
    localparam int CMP_W   = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int ENTRY_W = REGION_W + TIME_W;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      max_entries_reg, max_entries_next;
    logic [CACHE_SLOTS-1:0] valid_reg, valid_next;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [REG_AW-1:0]     clr_idx_reg, clr_idx_next;

    logic [REGION_W-1:0]   req_region_reg, req_region_next;
    logic [TIME_W-1:0]     req_now_reg, req_now_next;
    logic                  req_ok_reg, req_ok_next;

    logic [SLOT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                  issue_on_reg, issue_on_next;
    logic                  dat_vld_reg, dat_vld_next;
    logic [SLOT_W-1:0]     dat_idx_reg, dat_idx_next;

    logic                  hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                  old_found_reg, old_found_next;
    logic [SLOT_W-1:0]     old_idx_reg, old_idx_next;
    logic [TIME_W-1:0]     old_time_reg, old_time_next;
    logic [REGION_W-1:0]   old_region_reg, old_region_next;
    logic                  free_found_reg, free_found_next;
    logic [SLOT_W-1:0]     free_idx_reg, free_idx_next;

    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_OUT_W-1:0] res_slot_reg, res_slot_next;
    logic                  res_ev_reg, res_ev_next;
    logic [REGION_W-1:0]   res_evreg_reg, res_evreg_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                  slot_we, slot_re;
    logic [SLOT_W-1:0]     slot_waddr, slot_raddr;
    logic [ENTRY_W-1:0]    slot_wdata, slot_rdata;
    logic                  miss_we, miss_re;
    logic [REG_AW-1:0]     miss_waddr, miss_raddr;
    logic                  miss_wdata, miss_rdata;

    logic [REGION_W-1:0]   s_region;
    logic [REGION_W-1:0]   cur_region;
    logic [TIME_W-1:0]     cur_time;
    logic                  cur_valid;
    logic                  full, evict, can_install;
    logic [SLOT_W-1:0]     inst_idx;

    rcoe_ram #(.WIDTH(ENTRY_W), .DEPTH(CACHE_SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    rcoe_ram #(.WIDTH(1), .DEPTH(NUM_REGIONS)) u_miss_ram (
        .aclk  (aclk),
        .we    (miss_we),
        .waddr (miss_waddr),
        .wdata (miss_wdata),
        .re    (miss_re),
        .raddr (miss_raddr),
        .rdata (miss_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign s_region   = s_tdata[REGION_W-1:0];
    assign cur_region = slot_rdata[REGION_W-1:0];
    assign cur_time   = slot_rdata[ENTRY_W-1:REGION_W];
    assign cur_valid  = valid_reg[dat_idx_reg];

    assign full = (CMP_W'(occ_reg) >= CMP_W'(max_entries_reg))
               || (CMP_W'(occ_reg) >= CMP_W'(CACHE_SLOTS));
    assign evict       = full && old_found_reg;
    assign can_install = evict || free_found_reg;
    assign inst_idx    = (evict && (!free_found_reg || (old_idx_reg < free_idx_reg)))
                       ? old_idx_reg : free_idx_reg;

    always_comb begin
        state_next       = state_reg;
        max_entries_next = max_entries_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        clr_idx_next     = clr_idx_reg;
        req_region_next  = req_region_reg;
        req_now_next     = req_now_reg;
        req_ok_next      = req_ok_reg;
        scan_idx_next    = scan_idx_reg;
        issue_on_next    = issue_on_reg;
        dat_vld_next     = 1'b0;
        dat_idx_next     = dat_idx_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        old_found_next   = old_found_reg;
        old_idx_next     = old_idx_reg;
        old_time_next    = old_time_reg;
        old_region_next  = old_region_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_ev_next      = res_ev_reg;
        res_evreg_next   = res_evreg_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        slot_we    = 1'b0;
        slot_waddr = inst_idx;
        slot_wdata = {req_now_reg, req_region_reg};
        slot_re    = 1'b0;
        slot_raddr = scan_idx_reg;
        miss_we    = 1'b0;
        miss_waddr = REG_AW'(req_region_reg);
        miss_wdata = 1'b1;
        miss_re    = 1'b0;
        miss_raddr = REG_AW'(s_region);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cfg_valid) begin
            max_entries_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                miss_we    = 1'b1;
                miss_waddr = clr_idx_reg;
                miss_wdata = 1'b0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == REG_AW'(NUM_REGIONS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_region_next = s_region;
                    req_now_next    = s_tdata[REGION_W+TIME_W-1:REGION_W];
                    req_ok_next     = s_tdata[REGION_W+TIME_W];
                    res_slot_next   = '0;
                    res_ev_next     = 1'b0;
                    res_evreg_next  = '0;
                    if (s_tuser == ACT_FLUSH) begin
                        valid_next      = '0;
                        occ_next        = '0;
                        res_status_next = STAT_FLUSHED;
                        state_next      = ST_RESULT;
                    end else if (int'(s_region) >= NUM_REGIONS) begin
                        res_status_next = STAT_KNOWN_MISSING;
                        state_next      = ST_RESULT;
                    end else begin
                        miss_re         = 1'b1;
                        scan_idx_next   = '0;
                        issue_on_next   = 1'b1;
                        hit_found_next  = 1'b0;
                        old_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_on_reg) begin
                    slot_re      = 1'b1;
                    dat_vld_next = 1'b1;
                    dat_idx_next = scan_idx_reg;
                    if (scan_idx_reg == SLOT_W'(CACHE_SLOTS - 1)) begin
                        issue_on_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                if (dat_vld_reg) begin
                    if (cur_valid && !hit_found_reg && (cur_region == req_region_reg)) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = dat_idx_reg;
                    end
                    if (cur_valid && (!old_found_reg || (cur_time < old_time_reg)
                        || ((cur_time == old_time_reg) && (cur_region < old_region_reg)))) begin
                        old_found_next  = 1'b1;
                        old_idx_next    = dat_idx_reg;
                        old_time_next   = cur_time;
                        old_region_next = cur_region;
                    end
                    if (!cur_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = dat_idx_reg;
                    end
                    if (dat_idx_reg == SLOT_W'(CACHE_SLOTS - 1)) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                state_next = ST_RESULT;
                if (hit_found_reg) begin
                    res_status_next = STAT_HIT;
                    res_slot_next   = SLOT_OUT_W'(hit_idx_reg);
                end else if (miss_rdata) begin
                    res_status_next = STAT_KNOWN_MISSING;
                end else begin
                    if (evict) begin
                        valid_next[old_idx_reg] = 1'b0;
                        res_ev_next    = 1'b1;
                        res_evreg_next = old_region_reg;
                    end
                    if (req_ok_reg && can_install) begin
                        slot_we              = 1'b1;
                        valid_next[inst_idx] = 1'b1;
                        occ_next = occ_reg - OCC_W'(evict) + 1'b1;
                        res_status_next = STAT_LOADED;
                        res_slot_next   = SLOT_OUT_W'(inst_idx);
                    end else begin
                        miss_we  = 1'b1;
                        occ_next = occ_reg - OCC_W'(evict);
                        res_status_next = STAT_NEW_MISSING;
                    end
                end
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({res_evreg_reg, res_ev_reg, res_slot_reg});
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            max_entries_reg <= MAX_ENTRIES_RESET;
            valid_reg       <= '0;
            occ_reg         <= '0;
            clr_idx_reg     <= '0;
            issue_on_reg    <= 1'b0;
            dat_vld_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            max_entries_reg <= max_entries_next;
            valid_reg       <= valid_next;
            occ_reg         <= occ_next;
            clr_idx_reg     <= clr_idx_next;
            issue_on_reg    <= issue_on_next;
            dat_vld_reg     <= dat_vld_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_region_reg <= req_region_next;
        req_now_reg    <= req_now_next;
        req_ok_reg     <= req_ok_next;
        scan_idx_reg   <= scan_idx_next;
        dat_idx_reg    <= dat_idx_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_time_reg   <= old_time_next;
        old_region_reg <= old_region_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_ev_reg     <= res_ev_next;
        res_evreg_reg  <= res_evreg_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

`default_nettype wire

>>> dv/tb_region_cache_oldest_evict.sv
// Self-checking testbench for region_cache_oldest_evict: a directed table, then random
// request phases under several slot limits, checked against an in-bench directory model.
// Depends on rcoe_pkg and the RTL of the block.
module tb_region_cache_oldest_evict import rcoe_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS   = 64;
    localparam int REGIONS = 16384;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
        logic [REGION_W-1:0]   evicted_region;
    } answer_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                act;
        logic [REGION_W-1:0] region;
        logic [TIME_W-1:0]   now;
        logic                ok;
        logic [CFG_W-1:0]    limit;
        logic                typed;
        answer_t             want;
    } stim_row_t;

    localparam answer_t NO_CHECK = '0;
    localparam int DIRECTED_ROWS = 25;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data;

    logic                cache_valid  [SLOTS];
    logic [REGION_W-1:0] cache_region [SLOTS];
    logic [TIME_W-1:0]   cache_stamp  [SLOTS];
    logic                region_missing [REGIONS];
    int                  cache_fill;
    logic [CFG_W-1:0]    cache_limit;

    answer_t   pending_answers[$];
    stim_row_t directed_rows [DIRECTED_ROWS];
    int        failures = 0;
    int        answers_taken = 0;
    bit        no_idle = 1'b0;

    region_cache_oldest_evict DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // Directory behavior: flush, hit, known missing, or miss with oldest-first eviction
    // when full, then install into the lowest free slot or mark the region missing.
    function automatic answer_t directory_lookup(input logic act, input logic [REGION_W-1:0] region,
                                                 input logic [TIME_W-1:0] now, input logic ok);
        answer_t r;
        int victim;
        bit found;
        r = '0;
        if (act == ACT_FLUSH) begin
            for (int i = 0; i < SLOTS; i++)
                cache_valid[i] = 1'b0;
            cache_fill = 0;
            r.status = STAT_FLUSHED;
            return r;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (cache_valid[i] && cache_region[i] == region) begin
                r.status = STAT_HIT;
                r.slot = SLOT_OUT_W'(i);
                return r;
            end
        end
        if (region_missing[region]) begin
            r.status = STAT_KNOWN_MISSING;
            return r;
        end
        if (cache_fill >= int'(cache_limit) || cache_fill >= SLOTS) begin
            found = 1'b0;
            victim = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (cache_valid[i] && (!found || cache_stamp[i] < cache_stamp[victim] ||
                    (cache_stamp[i] == cache_stamp[victim] &&
                     cache_region[i] < cache_region[victim]))) begin
                    victim = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                cache_valid[victim] = 1'b0;
                if (cache_fill > 0)
                    cache_fill--;
                r.evicted = 1'b1;
                r.evicted_region = cache_region[victim];
            end
        end
        if (ok) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!cache_valid[i]) begin
                    cache_valid[i] = 1'b1;
                    cache_region[i] = region;
                    cache_stamp[i] = now;
                    cache_fill++;
                    r.status = STAT_LOADED;
                    r.slot = SLOT_OUT_W'(i);
                    return r;
                end
            end
        end
        region_missing[region] = 1'b1;
        r.status = STAT_NEW_MISSING;
        return r;
    endfunction

    task automatic check_answer();
        answer_t want;
        answer_t got;
        got.status = m_tuser;
        got.slot = m_tdata[5:0];
        got.evicted = m_tdata[6];
        got.evicted_region = m_tdata[20:7];
        if (pending_answers.size() == 0) begin
            $error("result with none expected: status %0d slot %0d", got.status, got.slot);
            failures++;
            return;
        end
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
        end
        if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            failures++;
        end
        if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
            failures++;
        end
        if (got.evicted_region !== want.evicted_region) begin
            $error("evicted_region: expected %0d, got %0d", want.evicted_region,
                   got.evicted_region);
            failures++;
        end
    endtask

    task automatic send_item(input logic act, input logic [REGION_W-1:0] region,
                             input logic [TIME_W-1:0] now, input logic ok,
                             input logic typed, input answer_t want);
        answer_t predicted;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, ok, now, region};
        s_tuser <= act;
        do @(posedge aclk); while (!s_tready);
        predicted = directory_lookup(act, region, now, ok);
        pending_answers.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] limit);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= limit;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cache_limit = limit;
    endtask

    // Most requests come from a narrow window of regions so that hits, evictions and
    // missing marks recur; the rest are spread over the whole region range.
    task automatic run_phase(input int count, input logic [CFG_W-1:0] limit, input int span,
                             input bit pause_midway);
        logic [REGION_W-1:0] base;
        logic [REGION_W-1:0] region;
        logic [TIME_W-1:0]   clock_s;
        logic [TIME_W-1:0]   now;
        logic                act;
        set_limit(limit);
        base = REGION_W'($urandom_range(0, REGIONS - 1));
        clock_s = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
        for (int k = 0; k < count; k++) begin
            no_idle = (k >= 30 && k < 70);
            if (pause_midway && k == count / 2)
                drain_results();
            act = ($urandom_range(0, 149) == 0) ? ACT_FLUSH : ACT_REQUEST;
            if ($urandom_range(0, 99) < 85)
                region = REGION_W'(base + $urandom_range(0, span - 1));
            else
                region = REGION_W'($urandom);
            clock_s = clock_s + $urandom_range(0, 3);
            case ($urandom_range(0, 49))
                0, 1: now = $urandom;
                2: now = 32'hFFFF_FFFF;
                default: now = clock_s;
            endcase
            send_item(act, region, now, $urandom_range(0, 99) < 88, 1'b0, NO_CHECK);
        end
        no_idle = 1'b0;
    endtask

    initial begin : answer_sink
        int hold;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                check_answer();
                answers_taken++;
                hold = (answers_taken == 150 || answers_taken == 600) ? 400 : pick_gap();
                if (hold > 0) begin
                    m_tready <= 1'b0;
                    repeat (hold) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t row;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_REQUEST;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < SLOTS; i++) begin
            cache_valid[i] = 1'b0;
            cache_region[i] = '0;
            cache_stamp[i] = '0;
        end
        for (int i = 0; i < REGIONS; i++)
            region_missing[i] = 1'b0;
        cache_fill = 0;
        cache_limit = MAX_ENTRIES_RESET;

        directed_rows = '{
            '{ROW_ITEM, ACT_REQUEST, 14'd0, 32'd0, 1'b1, 7'd0, 1'b1,
              '{STAT_LOADED, 6'd0, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd16383, 32'hFFFF_FFFF, 1'b1, 7'd0, 1'b1,
              '{STAT_LOADED, 6'd1, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd0, 32'd9, 1'b1, 7'd0, 1'b1,
              '{STAT_HIT, 6'd0, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd16383, 32'd1, 1'b0, 7'd0, 1'b1,
              '{STAT_HIT, 6'd1, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd100, 32'd2, 1'b0, 7'd0, 1'b1,
              '{STAT_NEW_MISSING, 6'd0, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd100, 32'd3, 1'b1, 7'd0, 1'b1,
              '{STAT_KNOWN_MISSING, 6'd0, 1'b0, 14'd0}},
            '{ROW_CFG, ACT_REQUEST, 14'd0, 32'd0, 1'b0, 7'd2, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'd200, 32'd4, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'd0, 32'd4, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'd300, 32'd5, 1'b0, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_FLUSH, 14'd12345, 32'd77, 1'b1, 7'd0, 1'b1,
              '{STAT_FLUSHED, 6'd0, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd5, 32'hFFFF_FFFF, 1'b1, 7'd0, 1'b1,
              '{STAT_LOADED, 6'd0, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd3, 32'hFFFF_FFFF, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'd9, 32'hFFFF_FFFF, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'd300, 32'd6, 1'b1, 7'd0, 1'b1,
              '{STAT_KNOWN_MISSING, 6'd0, 1'b0, 14'd0}},
            '{ROW_CFG, ACT_REQUEST, 14'd0, 32'd0, 1'b0, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_FLUSH, 14'd0, 32'd0, 1'b0, 7'd0, 1'b1,
              '{STAT_FLUSHED, 6'd0, 1'b0, 14'd0}},
            '{ROW_ITEM, ACT_REQUEST, 14'd7, 32'd10, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'd8, 32'd11, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_CFG, ACT_REQUEST, 14'd0, 32'd0, 1'b0, 7'd127, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'd8, 32'd12, 1'b0, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'h2AAA, 32'hAAAA_AAAA, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'h1555, 32'h5555_5555, 1'b1, 7'd0, 1'b0, NO_CHECK},
            '{ROW_CFG, ACT_REQUEST, 14'd0, 32'd0, 1'b0, 7'd64, 1'b0, NO_CHECK},
            '{ROW_ITEM, ACT_REQUEST, 14'h3FFF, 32'd0, 1'b0, 7'd0, 1'b0, NO_CHECK}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                set_limit(row.limit);
            else
                send_item(row.act, row.region, row.now, row.ok, row.typed, row.want);
        end

        run_phase(155, 7'd64, 96, 1'b0);
        run_phase(155, 7'd1, 8, 1'b0);
        run_phase(155, 7'd127, 100, 1'b1);
        run_phase(155, 7'd23, 40, 1'b0);
        run_phase(155, CFG_W'($urandom_range(2, 63)), 80, 1'b0);
        run_phase(155, MAX_ENTRIES_RESET, 64, 1'b0);

        drain_results();
        repeat (100) @(posedge aclk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
